### src/arp_overhead_header_insert_remove_core_macros.svh
// ---------------------------------------------------------------------------
// ARP overhead rewriter assertion macros
// Shared concurrent check wrappers, clocked on clk, held off during reset.
// ---------------------------------------------------------------------------
`ifndef ARP_OVERHEAD_HEADER_INSERT_REMOVE_CORE_MACROS_SVH
`define ARP_OVERHEAD_HEADER_INSERT_REMOVE_CORE_MACROS_SVH

// cons must hold in the same cycle as ante
`define OHIR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define OHIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ohir_pkg.sv
// ---------------------------------------------------------------------------
// ohir_pkg
// Types and constants shared by the ARP overhead rewriter modules.
// ---------------------------------------------------------------------------
package ohir_pkg;

  // hold store index width, covers the largest hold depth (10 + 16 nonce bytes)
  localparam int HOLD_IDX_W = 5;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] ARP_ETYPE      = 16'h0806;
  localparam logic [15:0] VLAN_ETYPE     = 16'h8100;
  localparam logic [15:0] PRIV_ETYPE_RST = 16'h88B6;

  // ethertype offsets without and with a VLAN tag
  localparam int ETYPE_OFF      = 12;
  localparam int VLAN_ETYPE_OFF = 16;
  // hold slot of the policy byte
  localparam int POLICY_IDX = 2;
  // minimum ARP body length
  localparam int MIN_BODY = 28;
  // length of the ARP body signature checked on detach
  localparam int SIG_LEN = 6;

  // status codes
  localparam logic [1:0] ST_REWRITTEN = 2'd0;
  localparam logic [1:0] ST_PASSED    = 2'd1;
  localparam logic [1:0] ST_SHORT     = 2'd2;

  // config register indexes
  localparam logic CFG_DIRECTION  = 1'b0;
  localparam logic CFG_PRIV_ETYPE = 1'b1;

  // direction codes
  localparam logic DIR_ATTACH = 1'b0;
  localparam logic DIR_DETACH = 1'b1;

  // work items passed from classifier to emitter
  typedef enum logic [6:0] {
    OP_BYTE    = 7'b0000001,  // emit b
    OP_PAIR    = 7'b0000010,  // emit a, then b
    OP_INSERT  = 7'b0000100,  // emit private ethertype, tag a, core, nonce
    OP_STORE2  = 7'b0001000,  // hold[0] = a, hold[1] = b
    OP_STORE   = 7'b0010000,  // hold[idx] = b
    OP_FLUSH   = 7'b0100000,  // hold[idx] = b, emit hold[0..idx]
    OP_RESTORE = 7'b1000000   // hold[idx] = b, emit ARP ethertype and body head
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [HOLD_IDX_W-1:0] idx;
    logic [7:0]            a;
    logic [7:0]            b;
    logic                  last;
    logic [1:0]            status;
    logic [7:0]            fpol;
    logic                  pvld;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } queue_head_t;

  // expected leading ARP body bytes: htype 1, ptype 0x0800, hlen 6, plen 4
  function automatic logic [7:0] body_sig(input logic [2:0] k);
    logic [7:0] v;
    case (k)
      3'd0:    v = 8'h00;
      3'd1:    v = 8'h01;
      3'd2:    v = 8'h08;
      3'd3:    v = 8'h00;
      3'd4:    v = 8'h06;
      3'd5:    v = 8'h04;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### src/arp_overhead_header_insert_remove_core.sv
// ---------------------------------------------------------------------------
// arp_overhead_header_insert_remove_core
// ARP overhead header insert/remove for Ethernet byte streams.
// Accepted bytes pass through the item queue and the output register. One byte
// per cycle when the output is not stalled; an insert emits 4+NONCE_BYTES bytes,
// a detach flush up to 10+NONCE_BYTES, a restore 8, set by the one-byte output
// port; the four-entry item queue holds input back while they drain.
// Reset: synchronous, active low; clears frame state and config registers.
// ---------------------------------------------------------------------------
`include "arp_overhead_header_insert_remove_core_macros.svh"

module arp_overhead_header_insert_remove_core #(
  parameter int NONCE_BYTES     = 12,
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [15:8] policy_tag
  input  logic        in_tlast,
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [9:8] status,
                                  // [17:10] found_policy, [18] policy_valid
  output logic        out_tlast,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic                  dir_r;
  logic [15:0]           pe_r;
  logic                  q_push;
  ohir_pkg::op_t         q_op;
  logic                  q_full;
  ohir_pkg::queue_head_t q_head;
  logic                  q_pop;
  logic [7:0]            o_byte;
  logic [1:0]            o_status;
  logic [7:0]            o_fpol;
  logic                  o_pvld;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= ohir_pkg::DIR_ATTACH;
      pe_r  <= ohir_pkg::PRIV_ETYPE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ohir_pkg::CFG_DIRECTION:  dir_r <= cfg_data[0];
        ohir_pkg::CFG_PRIV_ETYPE: pe_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // classifier
  ohir_front #(
    .NONCE_BYTES     (NONCE_BYTES),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata[7:0]),
    .in_last    (in_tlast),
    .in_tag     (in_tdata[15:8]),
    .direction  (dir_r),
    .priv_etype (pe_r),
    .push       (q_push),
    .push_op    (q_op),
    .q_full     (q_full)
  );

  // item queue
  ohir_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_op),
    .full    (q_full),
    .head    (q_head),
    .pop     (q_pop)
  );

  // emitter
  ohir_back #(
    .NONCE_BYTES (NONCE_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .pop        (q_pop),
    .priv_etype (pe_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (o_byte),
    .out_last   (out_tlast),
    .out_status (o_status),
    .out_fpol   (o_fpol),
    .out_pvld   (o_pvld)
  );

  assign out_tdata = {5'b00000, o_pvld, o_fpol, o_status, o_byte};

  // checks
  `OHIR_ASSERT_SAME(a_status_on_last, out_tvalid && !out_tlast, out_tdata[9:8] == ohir_pkg::ST_REWRITTEN, "status set on a beat that is not last")
  `OHIR_ASSERT_SAME(a_policy_zero, out_tvalid && !out_tdata[18], out_tdata[17:10] == 8'h00, "policy byte shown without policy_valid")
  `OHIR_ASSERT_SAME(a_pop_nonempty, q_pop, q_head.valid, "emitter popped an empty queue")
  `OHIR_ASSERT_NEXT(a_cfg_dir, cfg_valid && cfg_ready && cfg_index == ohir_pkg::CFG_DIRECTION, dir_r == $past(cfg_data[0]), "direction write lost")

endmodule

### src/ohir_front.sv
// ---------------------------------------------------------------------------
// ohir_front
// Input classifier: tracks frame position and phase, decides the ethertype
// handling and pushes one work item per input byte, bar a held ethertype byte.
// ---------------------------------------------------------------------------
module ohir_front #(
  parameter int NONCE_BYTES     = 12,
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic [7:0]        in_tag,
  input  logic              direction,
  input  logic [15:0]       priv_etype,
  output logic              push,
  output ohir_pkg::op_t     push_op,
  input  logic              q_full
);

  localparam int HOLD_DEPTH = 10 + NONCE_BYTES;
  localparam int SIG_START  = 4 + NONCE_BYTES;
  localparam int POS_W      = $clog2(MAX_FRAME_BYTES);
  localparam int POS_MAX    = MAX_FRAME_BYTES - 1;
  localparam int IW         = ohir_pkg::HOLD_IDX_W;

  typedef enum logic [3:0] {
    PH_HEAD = 4'b0001,
    PH_PASS = 4'b0010,
    PH_OVH  = 4'b0100,
    PH_BODY = 4'b1000
  } phase_t;

  logic [POS_W-1:0] pos_r, pos_nxt;
  phase_t           phase_r, phase_nxt;
  logic             vlan_r, vlan_nxt;
  logic [7:0]       tag_r, tag_nxt;
  logic             outcome_r, outcome_nxt;
  logic [7:0]       h0_r, h0_nxt;
  logic             match_r, match_nxt;

  logic             fire;
  logic [POS_W-1:0] etoff;
  logic [POS_W-1:0] next_pos;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    sig_diff;
  logic             in_sig;
  logic             sig_ok;
  logic [15:0]      etype;
  logic [7:0]       tag_cur;
  logic             outcome_cur;
  logic             push_c;
  ohir_pkg::op_t    op_c;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  // position helpers
  assign etoff    = vlan_r ? POS_W'(ohir_pkg::VLAN_ETYPE_OFF) : POS_W'(ohir_pkg::ETYPE_OFF);
  assign next_pos = (pos_r == POS_W'(POS_MAX)) ? pos_r : pos_r + 1'b1;
  assign idx      = IW'(pos_r - etoff);
  assign etype    = {h0_r, in_byte};

  // running check of the ARP body signature while held
  assign sig_diff = idx - IW'(SIG_START);
  assign in_sig   = (idx >= IW'(SIG_START));
  assign sig_ok   = (in_byte == ohir_pkg::body_sig(sig_diff[2:0]));

  // tag and policy flag as seen by this byte's output
  always_comb begin
    tag_cur     = tag_r;
    outcome_cur = outcome_r;
    if (phase_r == PH_HEAD && pos_r == '0) begin
      tag_cur = in_tag;
    end
    if (phase_r == PH_OVH && idx == IW'(ohir_pkg::POLICY_IDX)) begin
      tag_cur     = in_byte;
      outcome_cur = 1'b1;
    end
  end

  // classification and next state
  always_comb begin
    push_c      = 1'b0;
    op_c.kind   = ohir_pkg::OP_BYTE;
    op_c.idx    = idx;
    op_c.a      = h0_r;
    op_c.b      = in_byte;
    op_c.last   = in_last;
    op_c.status = ohir_pkg::ST_PASSED;
    op_c.fpol   = outcome_cur ? tag_cur : 8'h00;
    op_c.pvld   = outcome_cur;
    pos_nxt     = pos_r;
    phase_nxt   = phase_r;
    vlan_nxt    = vlan_r;
    tag_nxt     = tag_r;
    outcome_nxt = outcome_r;
    h0_nxt      = h0_r;
    match_nxt   = match_r;
    if (fire) begin
      tag_nxt     = tag_cur;
      outcome_nxt = outcome_cur;
      pos_nxt     = next_pos;
      case (phase_r)
        PH_HEAD: begin
          if (pos_r < etoff) begin
            push_c = 1'b1;
          end else if (pos_r == etoff) begin
            if (in_last) begin
              push_c = 1'b1;
            end else begin
              h0_nxt = in_byte;
            end
          end else if (!vlan_r && etype == ohir_pkg::VLAN_ETYPE) begin
            push_c    = 1'b1;
            op_c.kind = ohir_pkg::OP_PAIR;
            vlan_nxt  = 1'b1;
          end else if (in_last) begin
            push_c    = 1'b1;
            op_c.kind = ohir_pkg::OP_PAIR;
          end else if (direction == ohir_pkg::DIR_ATTACH && etype == ohir_pkg::ARP_ETYPE) begin
            push_c      = 1'b1;
            op_c.kind   = ohir_pkg::OP_INSERT;
            op_c.a      = tag_cur;
            op_c.status = ohir_pkg::ST_REWRITTEN;
            phase_nxt   = PH_BODY;
            pos_nxt     = '0;
          end else if (direction == ohir_pkg::DIR_DETACH && etype == priv_etype) begin
            push_c    = 1'b1;
            op_c.kind = ohir_pkg::OP_STORE2;
            phase_nxt = PH_OVH;
            match_nxt = 1'b1;
          end else begin
            push_c    = 1'b1;
            op_c.kind = ohir_pkg::OP_PAIR;
            phase_nxt = PH_PASS;
          end
        end
        PH_OVH: begin
          push_c    = 1'b1;
          op_c.kind = ohir_pkg::OP_STORE;
          if (in_sig && !sig_ok) begin
            match_nxt = 1'b0;
          end
          if (in_last) begin
            op_c.kind = ohir_pkg::OP_FLUSH;
          end else if (idx == IW'(HOLD_DEPTH - 1)) begin
            if (match_r && sig_ok) begin
              op_c.kind   = ohir_pkg::OP_RESTORE;
              op_c.status = ohir_pkg::ST_REWRITTEN;
              phase_nxt   = PH_BODY;
              pos_nxt     = POS_W'(ohir_pkg::SIG_LEN);
            end else begin
              op_c.kind = ohir_pkg::OP_FLUSH;
              phase_nxt = PH_PASS;
            end
          end
        end
        PH_BODY: begin
          push_c      = 1'b1;
          op_c.status = (next_pos < POS_W'(ohir_pkg::MIN_BODY)) ?
                        ohir_pkg::ST_SHORT : ohir_pkg::ST_REWRITTEN;
        end
        default: begin
          push_c = 1'b1;
        end
      endcase
      // frame end: back to header phase
      if (in_last) begin
        phase_nxt   = PH_HEAD;
        vlan_nxt    = 1'b0;
        outcome_nxt = 1'b0;
        pos_nxt     = '0;
      end
    end
  end

  assign push    = push_c;
  assign push_op = op_c;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      phase_r   <= PH_HEAD;
      vlan_r    <= 1'b0;
      tag_r     <= 8'h00;
      outcome_r <= 1'b0;
      match_r   <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
      vlan_r    <= vlan_nxt;
      tag_r     <= tag_nxt;
      outcome_r <= outcome_nxt;
      match_r   <= match_nxt;
    end
  end

  // first ethertype byte
  always_ff @(posedge clk) begin
    h0_r <= h0_nxt;
  end

endmodule

### src/ohir_queue.sv
// ---------------------------------------------------------------------------
// ohir_queue
// Short FIFO of work items between classifier and emitter.
// ---------------------------------------------------------------------------
module ohir_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ohir_pkg::op_t         push_op,
  output logic                  full,
  output ohir_pkg::queue_head_t head,
  input  logic                  pop
);

  localparam int DEPTH = ohir_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  ohir_pkg::op_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (count_r == (PTR_W + 1)'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.op    = mem_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && head.valid;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

### src/ohir_back.sv
// ---------------------------------------------------------------------------
// ohir_back
// Emitter: expands work items into output beats, owns the hold store and
// the output register.
// ---------------------------------------------------------------------------
module ohir_back #(
  parameter int NONCE_BYTES = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ohir_pkg::queue_head_t head,
  output logic                  pop,
  input  logic [15:0]           priv_etype,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_last,
  output logic [1:0]            out_status,
  output logic [7:0]            out_fpol,
  output logic                  out_pvld
);

  localparam int HOLD_DEPTH   = 10 + NONCE_BYTES;
  localparam int HIDX_W       = $clog2(HOLD_DEPTH);
  localparam int CW           = ohir_pkg::HOLD_IDX_W;
  localparam int INSERT_BEATS = 4 + NONCE_BYTES;
  // two ethertype beats plus the checked body bytes
  localparam int RESTORE_BEATS = 2 + ohir_pkg::SIG_LEN;
  // restore read offset; beat 2 reads hold slot 4 + NONCE_BYTES
  localparam int RESTORE_OFF  = 2 + NONCE_BYTES;

  ohir_pkg::op_t op;
  logic [7:0]    hold_r [HOLD_DEPTH];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] last_cnt;
  logic          final_beat;
  logic          is_store;
  logic          emit_ok;
  logic          beat;
  logic [CW-1:0] rd_sel;
  logic [7:0]    rd_data;
  logic [7:0]    beat_byte;
  logic          beat_last;
  logic          wr_en;
  logic          wr0_en;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r;
  logic          out_last_r;
  logic [1:0]    out_status_r;
  logic [7:0]    out_fpol_r;
  logic          out_pvld_r;

  assign op = head.op;

  // beats per item
  always_comb begin
    case (op.kind)
      ohir_pkg::OP_PAIR:    last_cnt = CW'(1);
      ohir_pkg::OP_INSERT:  last_cnt = CW'(INSERT_BEATS - 1);
      ohir_pkg::OP_FLUSH:   last_cnt = op.idx;
      ohir_pkg::OP_RESTORE: last_cnt = CW'(RESTORE_BEATS - 1);
      default:              last_cnt = '0;
    endcase
  end

  assign is_store   = (op.kind == ohir_pkg::OP_STORE) || (op.kind == ohir_pkg::OP_STORE2);
  assign emit_ok    = !out_valid_r || out_ready;
  assign beat       = head.valid && !is_store && emit_ok;
  assign final_beat = (cnt_r == last_cnt);
  assign pop        = head.valid && (is_store || (emit_ok && final_beat));
  assign cnt_nxt    = beat ? (final_beat ? '0 : cnt_r + 1'b1) : cnt_r;

  // hold store writes: stores at once, flush and restore on their first beat
  assign wr_en  = head.valid && (is_store ||
                  (beat && cnt_r == '0 &&
                   (op.kind == ohir_pkg::OP_FLUSH || op.kind == ohir_pkg::OP_RESTORE)));
  assign wr0_en = head.valid && (op.kind == ohir_pkg::OP_STORE2);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hold_r[op.idx[HIDX_W-1:0]] <= op.b;
    end
    if (wr0_en) begin
      hold_r[0] <= op.a;
    end
  end

  // hold store read
  assign rd_sel  = (op.kind == ohir_pkg::OP_RESTORE) ? cnt_r + CW'(RESTORE_OFF) : cnt_r;
  assign rd_data = hold_r[rd_sel[HIDX_W-1:0]];

  // beat data
  always_comb begin
    case (op.kind)
      ohir_pkg::OP_PAIR: begin
        beat_byte = (cnt_r == '0) ? op.a : op.b;
      end
      ohir_pkg::OP_INSERT: begin
        if (cnt_r == CW'(0)) begin
          beat_byte = priv_etype[15:8];
        end else if (cnt_r == CW'(1)) begin
          beat_byte = priv_etype[7:0];
        end else if (cnt_r == CW'(ohir_pkg::POLICY_IDX)) begin
          beat_byte = op.a;
        end else begin
          beat_byte = 8'h00;
        end
      end
      ohir_pkg::OP_FLUSH: begin
        beat_byte = rd_data;
      end
      ohir_pkg::OP_RESTORE: begin
        if (cnt_r == CW'(0)) begin
          beat_byte = ohir_pkg::ARP_ETYPE[15:8];
        end else if (cnt_r == CW'(1)) begin
          beat_byte = ohir_pkg::ARP_ETYPE[7:0];
        end else begin
          beat_byte = rd_data;
        end
      end
      default: begin
        beat_byte = op.b;
      end
    endcase
  end

  assign beat_last = final_beat && op.last;

  // output register
  assign out_valid_nxt = beat ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      out_byte_r   <= beat_byte;
      out_last_r   <= beat_last;
      out_status_r <= beat_last ? op.status : ohir_pkg::ST_REWRITTEN;
      out_fpol_r   <= op.fpol;
      out_pvld_r   <= op.pvld;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;
  assign out_fpol   = out_fpol_r;
  assign out_pvld   = out_pvld_r;

endmodule

### tb/tb_arp_overhead_header_insert_remove_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ARP overhead rewriter testbench
// Streams Ethernet frames through the core under several direction and
// ethertype settings and checks every output beat against a cycle-free
// byte-level predictor. Directed frames cover the corner cases, random frames
// follow; both stream sides idle at random, with one long output stall.
// ---------------------------------------------------------------------------
module tb_arp_overhead_header_insert_remove_core;

  localparam int NONCE_BYTES     = 12;
  // small frame limit, so that a long frame reaches the counter limit
  localparam int MAX_FRAME_BYTES = 64;
  localparam int HOLD_DEPTH      = 10 + NONCE_BYTES;
  localparam int BODY_SLOT       = 4 + NONCE_BYTES;
  localparam int RAND_FRAMES     = 1;
  localparam int SQUEEZE_CYCLES  = 300;
  localparam int DRAIN_LIMIT     = 20000;

  // leading ARP body bytes that allow a detach
  localparam logic [7:0] ARP_SIG [ohir_pkg::SIG_LEN] =
    '{8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04};

  typedef enum logic [3:0] {
    FR_HEADER = 4'b0001,
    FR_PASS   = 4'b0010,
    FR_HELD   = 4'b0100,
    FR_BODY   = 4'b1000
  } frame_state_t;
  typedef enum logic [1:0] {FK_ARP, FK_PRIV, FK_OTHER, FK_DOUBLE_VLAN} frame_kind_t;
  typedef enum logic [1:0] {GAP_RX_HEAVY, GAP_TX_HEAVY, GAP_NONE} gap_mode_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic [7:0] tag;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
    logic [7:0] fpol;
    logic       pvld;
  } out_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [7:0] data_byte, [15:8] policy_tag
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [7:0] out_byte, [9:8] status,
                                // [17:10] found_policy, [18] policy_valid
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = ohir_pkg::CFG_DIRECTION;
  logic [15:0] cfg_data = '0;

  arp_overhead_header_insert_remove_core #(
    .NONCE_BYTES     (NONCE_BYTES),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  in_beat_t  frame_q[$];       // beats waiting to be driven
  in_beat_t  cur_beat;
  out_beat_t rewritten_q[$];   // predicted output beats
  out_beat_t want;
  gap_mode_t gap_mode = GAP_RX_HEAVY;
  int        err_cnt = 0;
  logic      squeeze_req = 1'b0;
  logic      squeeze_done = 1'b0;
  int        squeeze_cnt = 0;

  // predictor state and its copy of the config registers
  logic         rw_dir;
  logic [15:0]  rw_priv;
  int           rw_pos;
  logic [7:0]   rw_hold [HOLD_DEPTH];
  frame_state_t rw_state;
  logic         rw_vlan;
  logic [7:0]   rw_tag;
  logic         rw_found;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic push_out_byte(input logic [7:0] b, input logic last, input logic [1:0] st);
    out_beat_t o;
    o.data   = b;
    o.last   = last;
    o.status = last ? st : ohir_pkg::ST_REWRITTEN;
    o.fpol   = rw_found ? rw_tag : 8'h00;
    o.pvld   = rw_found;
    rewritten_q.push_back(o);
  endtask

  task automatic push_held(input int from, input int upto, input logic last);
    for (int i = from; i <= upto && i < HOLD_DEPTH; i++)
      push_out_byte(rw_hold[i], last && (i == upto), ohir_pkg::ST_PASSED);
  endtask

  task automatic clear_frame();
    rw_pos   = 0;
    rw_state = FR_HEADER;
    rw_vlan  = 1'b0;
    rw_found = 1'b0;
  endtask

  task automatic rewrite_byte(input logic [7:0] b, input logic last, input logic [7:0] tag);
    int          etoff;
    int          nxt;
    int          idx;
    logic [15:0] et;
    logic        sig_ok;
    logic        settled;
    etoff   = rw_vlan ? ohir_pkg::VLAN_ETYPE_OFF : ohir_pkg::ETYPE_OFF;
    nxt     = (rw_pos + 1 < MAX_FRAME_BYTES) ? rw_pos + 1 : MAX_FRAME_BYTES - 1;
    settled = 1'b0;
    case (rw_state)
      FR_HEADER: begin
        if (rw_pos == 0) rw_tag = tag;
        if (rw_pos < etoff) begin
          push_out_byte(b, last, ohir_pkg::ST_PASSED);
        end else if (rw_pos == etoff) begin
          if (last) push_out_byte(b, 1'b1, ohir_pkg::ST_PASSED);
          else rw_hold[0] = b;
        end else begin
          et = {rw_hold[0], b};
          if (!rw_vlan && et == ohir_pkg::VLAN_ETYPE) begin
            push_out_byte(rw_hold[0], 1'b0, ohir_pkg::ST_PASSED);
            push_out_byte(b, last, ohir_pkg::ST_PASSED);
            rw_vlan = 1'b1;
          end else if (last) begin
            push_out_byte(rw_hold[0], 1'b0, ohir_pkg::ST_PASSED);
            push_out_byte(b, 1'b1, ohir_pkg::ST_PASSED);
          end else if (rw_dir == ohir_pkg::DIR_ATTACH && et == ohir_pkg::ARP_ETYPE) begin
            // private ethertype, tag, core byte, zero nonce
            push_out_byte(rw_priv[15:8], 1'b0, ohir_pkg::ST_REWRITTEN);
            push_out_byte(rw_priv[7:0], 1'b0, ohir_pkg::ST_REWRITTEN);
            push_out_byte(rw_tag, 1'b0, ohir_pkg::ST_REWRITTEN);
            push_out_byte(8'h00, 1'b0, ohir_pkg::ST_REWRITTEN);
            for (int i = 0; i < NONCE_BYTES; i++)
              push_out_byte(8'h00, 1'b0, ohir_pkg::ST_REWRITTEN);
            rw_state = FR_BODY;
            rw_pos   = 0;
            settled  = 1'b1;
          end else if (rw_dir == ohir_pkg::DIR_DETACH && et == rw_priv) begin
            rw_hold[1] = b;
            rw_state   = FR_HELD;
          end else begin
            push_out_byte(rw_hold[0], 1'b0, ohir_pkg::ST_PASSED);
            push_out_byte(b, 1'b0, ohir_pkg::ST_PASSED);
            rw_state = FR_PASS;
          end
        end
      end
      FR_HELD: begin
        idx = rw_pos - etoff;
        if (rw_pos < etoff || idx >= HOLD_DEPTH) begin
          push_out_byte(b, last, ohir_pkg::ST_PASSED);
          rw_state = FR_PASS;
        end else begin
          rw_hold[idx] = b;
          if (idx == ohir_pkg::POLICY_IDX) begin
            rw_tag   = b;
            rw_found = 1'b1;
          end
          if (last) begin
            push_held(0, idx, 1'b1);
          end else if (idx == HOLD_DEPTH - 1) begin
            sig_ok = 1'b1;
            for (int k = 0; k < ohir_pkg::SIG_LEN; k++)
              if (rw_hold[BODY_SLOT + k] != ARP_SIG[k]) sig_ok = 1'b0;
            if (sig_ok) begin
              push_out_byte(ohir_pkg::ARP_ETYPE[15:8], 1'b0, ohir_pkg::ST_REWRITTEN);
              push_out_byte(ohir_pkg::ARP_ETYPE[7:0], 1'b0, ohir_pkg::ST_REWRITTEN);
              push_held(BODY_SLOT, idx, 1'b0);
              rw_state = FR_BODY;
              rw_pos   = ohir_pkg::SIG_LEN;
              settled  = 1'b1;
            end else begin
              push_held(0, idx, 1'b0);
              rw_state = FR_PASS;
            end
          end
        end
      end
      FR_BODY: push_out_byte(b, last, (nxt >= ohir_pkg::MIN_BODY) ?
                             ohir_pkg::ST_REWRITTEN : ohir_pkg::ST_SHORT);
      default: push_out_byte(b, last, ohir_pkg::ST_PASSED);
    endcase
    if (!settled) begin
      if (last) clear_frame();
      else rw_pos = nxt;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Frame builder: cut = 0 keeps the whole frame, -1 cuts at random,
  // otherwise the frame ends after cut bytes. bad_sig >= 0 corrupts one
  // signature byte of the ARP body.
  // ---------------------------------------------------------------------------
  task automatic add_frame(input frame_kind_t kind, input logic vlan, input int body_len,
                           input int cut, input int bad_sig);
    logic [7:0]  f[$];
    logic [15:0] et;
    int          n;
    in_beat_t    bt;
    for (int i = 0; i < 12; i++) f.push_back(8'($urandom_range(0, 255)));
    if (vlan || kind == FK_DOUBLE_VLAN) begin
      f.push_back(ohir_pkg::VLAN_ETYPE[15:8]);
      f.push_back(ohir_pkg::VLAN_ETYPE[7:0]);
      f.push_back(8'($urandom_range(0, 255)));
      f.push_back(8'($urandom_range(0, 255)));
    end
    case (kind)
      FK_ARP:         et = ohir_pkg::ARP_ETYPE;
      FK_PRIV:        et = rw_priv;
      FK_DOUBLE_VLAN: et = ohir_pkg::VLAN_ETYPE;
      default:        et = 16'($urandom_range(0, 16'hFFFF));
    endcase
    f.push_back(et[15:8]);
    f.push_back(et[7:0]);
    // policy, core byte and nonce of an overhead header
    if (kind == FK_PRIV)
      for (int i = 0; i < 2 + NONCE_BYTES; i++) f.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < body_len; i++) begin
      if (i < ohir_pkg::SIG_LEN)
        f.push_back((i == bad_sig) ? ARP_SIG[i] ^ 8'($urandom_range(1, 255)) : ARP_SIG[i]);
      else f.push_back(8'($urandom_range(0, 255)));
    end
    n = f.size();
    if (cut < 0) n = $urandom_range(1, f.size());
    else if (cut > 0 && cut < n) n = cut;
    for (int i = 0; i < n; i++) begin
      bt.data = f[i];
      bt.last = (i == n - 1);
      bt.tag  = 8'($urandom_range(0, 255));
      frame_q.push_back(bt);
    end
  endtask

  task automatic add_random_frames(input int frames);
    int          r;
    frame_kind_t kind;
    int          body;
    for (int j = 0; j < frames; j++) begin
      r = $urandom_range(0, 99);
      if (r < 35) kind = FK_ARP;
      else if (r < 70) kind = FK_PRIV;
      else if (r < 85) kind = FK_OTHER;
      else kind = FK_DOUBLE_VLAN;
      // mostly bodies around the minimum length, a few anywhere
      body = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80) : $urandom_range(20, 36);
      add_frame(kind, $urandom_range(0, 3) == 0, body,
                ($urandom_range(0, 7) == 0) ? -1 : 0,
                ($urandom_range(0, 4) == 0) ? $urandom_range(0, ohir_pkg::SIG_LEN - 1) : -1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Config writes, only while the core is idle
  // ---------------------------------------------------------------------------
  task automatic set_config(input logic dir, input logic [15:0] etype);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ohir_pkg::CFG_DIRECTION;
    cfg_data  <= {15'd0, dir};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= ohir_pkg::CFG_PRIV_ETYPE;
    cfg_data  <= etype;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rw_dir  = dir;
    rw_priv = etype;
  endtask

  function automatic logic core_busy();
    return frame_q.size() != 0 || in_tvalid || rewritten_q.size() != 0;
  endfunction

  task automatic wait_drained();
    do @(negedge clk); while (core_busy());
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) rewrite_byte(cur_beat.data, cur_beat.last, cur_beat.tag);
      if (!in_tvalid || in_tready) begin
        if (frame_q.size() != 0 &&
            !(gap_mode == GAP_RX_HEAVY && $urandom_range(0, 99) < 27) &&
            !(gap_mode == GAP_TX_HEAVY && $urandom_range(0, 99) < 81)) begin
          cur_beat  = frame_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {cur_beat.tag, cur_beat.data};
          in_tlast  <= cur_beat.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long output stall, counted on its own
  always @(posedge clk) begin
    if (squeeze_req && !squeeze_done) begin
      squeeze_cnt  <= SQUEEZE_CYCLES;
      squeeze_done <= 1'b1;
    end else if (squeeze_cnt != 0) begin
      squeeze_cnt <= squeeze_cnt - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (rewritten_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected beat, expected none, actual %02h", $time,
                   out_tdata[7:0]);
        end else begin
          want = rewritten_q.pop_front();
          check_field("out_byte", want.data, out_tdata[7:0]);
          check_field("out_last", want.last, out_tlast);
          check_field("status", want.status, out_tdata[9:8]);
          check_field("found_policy", want.fpol, out_tdata[17:10]);
          check_field("policy_valid", want.pvld, out_tdata[18]);
        end
      end
      if (squeeze_cnt != 0) out_tready <= 1'b0;
      else if (gap_mode == GAP_RX_HEAVY) out_tready <= ($urandom_range(0, 99) >= 81);
      else if (gap_mode == GAP_TX_HEAVY) out_tready <= ($urandom_range(0, 99) >= 27);
      else out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic        dirs   [6];
    logic [15:0] etypes [6];
    int          waited;
    dirs   = '{ohir_pkg::DIR_ATTACH, ohir_pkg::DIR_DETACH, ohir_pkg::DIR_ATTACH,
               ohir_pkg::DIR_DETACH, ohir_pkg::DIR_DETACH, ohir_pkg::DIR_ATTACH};
    etypes = '{ohir_pkg::PRIV_ETYPE_RST, ohir_pkg::PRIV_ETYPE_RST, 16'hFFFF, 16'h0000,
               ohir_pkg::VLAN_ETYPE, 16'h0000};
    dirs[5]   = 1'($urandom_range(0, 1));
    etypes[5] = 16'($urandom_range(0, 16'hFFFF));
    rw_dir  = ohir_pkg::DIR_ATTACH;
    rw_priv = ohir_pkg::PRIV_ETYPE_RST;
    rw_tag  = 8'h00;
    foreach (rw_hold[i]) rw_hold[i] = 8'h00;
    clear_frame();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      gap_mode = (ph < 2) ? GAP_RX_HEAVY : (ph < 4) ? GAP_TX_HEAVY : GAP_NONE;
      set_config(dirs[ph], etypes[ph]);
      @(negedge clk);
      if (ph == 0) begin
        add_frame(FK_OTHER, 1'b0, 0, 1, -1);          // single-byte frame
        add_frame(FK_ARP, 1'b0, 10, 13, -1);          // ends on ethertype high byte
        add_frame(FK_ARP, 1'b0, 10, 14, -1);          // ends on ethertype low byte
        add_frame(FK_ARP, 1'b1, 4, 0, -1);            // tagged ARP, short body
        add_frame(FK_DOUBLE_VLAN, 1'b1, 0, 0, -1);    // second tag is an ethertype
        add_frame(FK_ARP, 1'b0, 65, 0, -1);           // counter saturation
      end else if (ph == 1) begin
        add_frame(FK_PRIV, 1'b0, 28, 0, -1);          // minimum body
        add_frame(FK_PRIV, 1'b0, 7, 0, -1);           // restored but short
        add_frame(FK_PRIV, 1'b0, 7, 0, 2);            // body check fails
        add_frame(FK_PRIV, 1'b0, 0, 15, -1);          // ends on the policy byte
      end else if (ph == 4) begin
        add_frame(FK_ARP, 1'b0, 10, 0, -1);
      end else begin
        add_random_frames(RAND_FRAMES);
      end
      // back-pressure while the sender keeps offering beats
      if (ph == 4) squeeze_req <= 1'b1;
      wait_drained();
    end

    waited = 0;
    while (core_busy() && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (rewritten_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d beats still expected, expected 0, actual %0d", $time,
               rewritten_q.size(), rewritten_q.size());
    end
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
